>>> src/assert_macros.svh
// Assertion macros used by accel_roll_sector_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is disabled while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked on every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/ars_pkg.sv
// Types and constants for the roll sector pipeline.
package ars_pkg;

  localparam int WORK_BITS     = 40;
  localparam int CORDIC_STEPS  = 30;
  localparam int XW            = 44;
  localparam int ACC_W         = 32;
  localparam int SCALE_W       = 11;
  localparam int SECTOR_W      = 10;
  localparam int NUM_SENSORS_W = 11;
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;
  localparam int REG_IDX_W     = 1;

  localparam logic [REG_IDX_W-1:0]     REG_NUM_SENSORS = 1'b0;
  localparam logic [NUM_SENSORS_W-1:0] NUM_SENSORS_RST = 11'd64;
  localparam logic [SECTOR_W-1:0]      SECTOR_MAX      = 10'h3FF;

  localparam logic [ACC_W-1:0] ANG_ZERO     = 32'h0000_0000;
  localparam logic [ACC_W-1:0] ANG_QUARTER  = 32'h4000_0000;
  localparam logic [ACC_W-1:0] ANG_HALF     = 32'h8000_0000;
  localparam logic [ACC_W-1:0] ANG_3QUARTER = 32'hC000_0000;

  // Angle of atan(2^-i) as a fraction of a full turn, 2^32 per turn.
  localparam logic [ACC_W-1:0] TURN_TABLE [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  typedef struct packed {
    logic                   special;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   w;
    logic [ACC_W-1:0]       acc;
  } cordic_t;

endpackage

>>> src/accel_roll_sector_top.sv
// An accepted request passes the entry stage, the rotation stages, prod_q and sector_q.
// Throughput: one request per cycle; each of the 30 CORDIC rotations has its own stage.
// The whole pipeline advances together and holds while the output register is stalled.
// Reset clears all valid bits and sets num_sensors to 64; no clearing pass is needed.
// Configuration writes take effect at once and are meant for an idle pipeline.
`include "assert_macros.svh"

module accel_roll_sector_top #(
  parameter int SAMPLE_BITS = 16,
  parameter int ANGLE_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ars_pkg::APB_AW-1:0]        paddr,
  input  logic [ars_pkg::APB_DW-1:0]        pwdata,
  output logic [ars_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]     accel_y_i,
  input  logic signed [SAMPLE_BITS-1:0]     accel_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ars_pkg::SECTOR_W-1:0]      sector_o
);
  import ars_pkg::*;

  localparam int PAD    = WORK_BITS - SAMPLE_BITS;
  localparam int PROD_W = ANGLE_BITS + SCALE_W;

  function automatic cordic_t cordic_step(input cordic_t s, input int unsigned k,
                                          input logic [ACC_W-1:0] ang);
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] w;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ws;
    cordic_t r;
    x  = s.x;
    w  = s.w;
    xs = x >>> k;
    ws = w >>> k;
    r  = s;
    if (!s.special) begin
      if (!w[XW-1] && (w != '0)) begin
        r.x   = x + ws;
        r.w   = w - xs;
        r.acc = s.acc + ang;
      end else begin
        r.x   = x - ws;
        r.w   = w + xs;
        r.acc = s.acc - ang;
      end
    end
    return r;
  endfunction

  logic [NUM_SENSORS_W-1:0] num_sensors_q;
  logic [REG_IDX_W-1:0]     reg_idx;
  logic                     cfg_wr;

  logic                     en;
  logic [CORDIC_STEPS:0]    stg_v_q;
  cordic_t                  stg_q [CORDIC_STEPS+1];
  cordic_t                  stg_d [CORDIC_STEPS+1];

  logic signed [XW-1:0]     y_ext;
  logic signed [XW-1:0]     z_ext;

  logic [ANGLE_BITS-1:0]    ang_trunc;
  logic [SCALE_W-1:0]       scale;
  logic [PROD_W-1:0]        prod_d;
  logic [PROD_W-1:0]        prod_q;
  logic                     prod_v_q;
  logic [SCALE_W-1:0]       sect_full;
  logic [SECTOR_W-1:0]      sector_d;
  logic [SECTOR_W-1:0]      sector_q;
  logic                     out_valid_q;

  // Register port.
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_idx == REG_NUM_SENSORS) ? APB_DW'(num_sensors_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_sensors_q <= NUM_SENSORS_RST;
    end else if (cfg_wr && (reg_idx == REG_NUM_SENSORS)) begin
      num_sensors_q <= pwdata[NUM_SENSORS_W-1:0];
    end
  end

  // The pipeline moves as one unless the output register holds an untaken result.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Entry stage: scaling, special angles and the half-turn prerotation.
  assign y_ext = {{(XW-WORK_BITS){accel_y_i[SAMPLE_BITS-1]}}, accel_y_i, {PAD{1'b0}}};
  assign z_ext = {{(XW-WORK_BITS){accel_z_i[SAMPLE_BITS-1]}}, accel_z_i, {PAD{1'b0}}};

  always_comb begin
    stg_d[0].special = 1'b0;
    stg_d[0].x       = z_ext;
    stg_d[0].w       = y_ext;
    stg_d[0].acc     = ANG_ZERO;
    if (accel_z_i == '0) begin
      stg_d[0].special = 1'b1;
      stg_d[0].acc     = accel_y_i[SAMPLE_BITS-1] ? ANG_3QUARTER : ANG_QUARTER;
    end else if (accel_y_i == '0) begin
      stg_d[0].special = 1'b1;
      stg_d[0].acc     = accel_z_i[SAMPLE_BITS-1] ? ANG_HALF : ANG_ZERO;
    end else if (accel_z_i[SAMPLE_BITS-1]) begin
      stg_d[0].x   = -z_ext;
      stg_d[0].w   = -y_ext;
      stg_d[0].acc = ANG_HALF;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    assign stg_d[k+1] = cordic_step(stg_q[k], k, TURN_TABLE[k]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= CORDIC_STEPS; k++) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // Scaling by the sensor count minus one, clamped to SECTOR_MAX.
  assign ang_trunc = stg_q[CORDIC_STEPS].acc[ACC_W-1 -: ANGLE_BITS];
  assign scale     = (num_sensors_q == '0) ? '0 : num_sensors_q - SCALE_W'(1);
  assign prod_d    = PROD_W'(ang_trunc) * PROD_W'(scale);

  assign sect_full = prod_q[PROD_W-1:ANGLE_BITS];
  assign sector_d  = (sect_full > SCALE_W'(SECTOR_MAX)) ? SECTOR_MAX
                                                        : sect_full[SECTOR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q   <= prod_d;
      sector_q <= sector_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q     <= '0;
      prod_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      stg_v_q     <= {stg_v_q[CORDIC_STEPS-1:0], in_valid_i};
      prod_v_q    <= stg_v_q[CORDIC_STEPS];
      out_valid_q <= prod_v_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sector_o    = sector_q;

  `ASSERT_RST(a_special_angle, clk_i, rst_ni, stg_v_q[0] && stg_q[0].special |-> (stg_q[0].acc == ANG_ZERO || stg_q[0].acc == ANG_QUARTER || stg_q[0].acc == ANG_HALF || stg_q[0].acc == ANG_3QUARTER), "Special case left a non-axis angle.")
  `ASSERT_RST(a_x_positive, clk_i, rst_ni, stg_v_q[CORDIC_STEPS] && !stg_q[CORDIC_STEPS].special |-> !stg_q[CORDIC_STEPS].x[XW-1], "CORDIC magnitude went negative.")
  `ASSERT_RST(a_prod_to_out, clk_i, rst_ni, en && prod_v_q |=> out_valid_o, "Product stage request was lost.")

endmodule

>>> dv/tb_accel_roll_sector_top.sv
// Self-checking testbench that streams sample pairs and checks each sector against a predictor.
module tb_accel_roll_sector_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ars_pkg::*;

  localparam int SAMPLE_BITS     = 16;
  localparam int ANGLE_BITS      = 16;
  localparam int PIPE_LATENCY    = 32;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int REPORT_LIMIT    = 10;
  localparam int DIRECTED_N      = 22;

  localparam logic [APB_AW-1:0] ADDR_NUM_SENSORS = {REG_NUM_SENSORS, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED    = ADDR_NUM_SENSORS + APB_AW'(4);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam int DIR_Y [DIRECTED_N] = '{
    0, 1, -1, 32767, -32768, 0, 0, 0, 0, 32767, -32768,
    32767, -32768, 1, -1, 1, -1, 1, -1, 32767, -32768, -21846
  };
  localparam int DIR_Z [DIRECTED_N] = '{
    0, 0, 0, 0, 0, 1, -1, 32767, -32768, 32767, -32768,
    -32768, 32767, 1, -1, -1, 1, -32768, 32767, 1, -1, 21845
  };

  class sector_board;
    logic [NUM_SENSORS_W-1:0] num_sensors;
    logic [SECTOR_W-1:0]      sector_q [$];
    int                       mismatches;

    function new();
      num_sensors = NUM_SENSORS_RST;
      mismatches  = 0;
    endfunction

    function void report(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%s mismatch: expected %0d, actual %0d", what, want, got);
      end
    endfunction

    function logic [ACC_W-1:0] roll_angle(longint y, longint z);
      longint           x;
      longint           w;
      longint           nx;
      longint           nw;
      logic [ACC_W-1:0] acc;
      int               i;
      if (z == 0) return (y < 0) ? ANG_3QUARTER : ANG_QUARTER;
      if (y == 0) return (z > 0) ? ANG_ZERO : ANG_HALF;
      x = z * (longint'(1) << (WORK_BITS - SAMPLE_BITS));
      w = y * (longint'(1) << (WORK_BITS - SAMPLE_BITS));
      acc = ANG_ZERO;
      if (x < 0) begin
        x = -x;
        w = -w;
        acc = ANG_HALF;
      end
      for (i = 0; i < CORDIC_STEPS; i++) begin
        if (w > 0) begin
          nx = x + (w >>> i);
          nw = w - (x >>> i);
          acc = acc + TURN_TABLE[i];
        end else begin
          nx = x - (w >>> i);
          nw = w + (x >>> i);
          acc = acc - TURN_TABLE[i];
        end
        x = nx;
        w = nw;
      end
      return acc;
    endfunction

    function void note_request(logic signed [SAMPLE_BITS-1:0] y,
                               logic signed [SAMPLE_BITS-1:0] z);
      longint ang;
      longint scale;
      longint sec;
      ang = longint'(roll_angle(longint'(y), longint'(z)) >> (ACC_W - ANGLE_BITS));
      scale = (num_sensors > 0) ? longint'(num_sensors) - 1 : 0;
      sec = (ang * scale) >> ANGLE_BITS;
      if (sec > longint'(SECTOR_MAX)) sec = longint'(SECTOR_MAX);
      sector_q.push_back(sec[SECTOR_W-1:0]);
    endfunction

    function void check_sector(logic [SECTOR_W-1:0] got);
      logic [SECTOR_W-1:0] want;
      if (sector_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("sector %0d arrived with no request pending", got);
        end
        return;
      end
      want = sector_q.pop_front();
      if (got !== want) report("sector", want, got);
    endfunction

    function int pending();
      return sector_q.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [APB_AW-1:0]             paddr;
  logic [APB_DW-1:0]             pwdata;
  logic [APB_DW-1:0]             prdata;
  logic                          pready;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic signed [SAMPLE_BITS-1:0] accel_y_i;
  logic signed [SAMPLE_BITS-1:0] accel_z_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [SECTOR_W-1:0]           sector_o;

  sector_board board = new();
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_left      = 0;

  accel_roll_sector_top #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .accel_y_i  (accel_y_i),
    .accel_z_i  (accel_z_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sector_o   (sector_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_request(accel_y_i, accel_z_i);
      if (out_valid_o && out_ready_i) board.check_sector(sector_o);
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("accel_roll_sector_top regression: fail");
    $finish;
  end

  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_NUM_SENSORS) board.num_sensors = data[NUM_SENSORS_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_sensors();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_NUM_SENSORS;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DW'(board.num_sensors)) begin
      board.report("num_sensors read", APB_DW'(board.num_sensors), prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_sensors(int count);
    apb_write(ADDR_NUM_SENSORS, ($urandom() & ~APB_DW'(32'h7FF)) | APB_DW'(count));
    apb_read_sensors();
  endtask

  task automatic send_req(logic signed [SAMPLE_BITS-1:0] y,
                          logic signed [SAMPLE_BITS-1:0] z);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_y_i  <= y;
    accel_z_i  <= z;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic void pick_pair(output logic signed [SAMPLE_BITS-1:0] y,
                                    output logic signed [SAMPLE_BITS-1:0] z);
    y = SAMPLE_BITS'($urandom());
    z = SAMPLE_BITS'($urandom());
    case ($urandom_range(9))
      0: y = '0;
      1: z = '0;
      2: begin
        y = SAMPLE_BITS'($urandom_range(8)) - SAMPLE_BITS'(4);
        z = SAMPLE_BITS'($urandom_range(8)) - SAMPLE_BITS'(4);
      end
      3: y = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      4: z = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      default: ;
    endcase
  endfunction

  task automatic run_phase(int count, int send_pct, int recv_pct, int n_req,
                           bit hold_off, int pause_every);
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] z;
    set_sensors(count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (hold_off) hold_left = HOLD_OFF_CYCLES;
    for (int k = 0; k < n_req; k++) begin
      pick_pair(y, z);
      send_req(y, z);
      if (pause_every > 0 && (k + 1) % pause_every == 0) wait_results();
    end
    wait_results();
  endtask

  initial begin
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    accel_y_i  = '0;
    accel_z_i  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    apb_read_sensors();
    for (int i = 0; i < DIRECTED_N; i++) begin
      send_req(SAMPLE_BITS'(DIR_Y[i]), SAMPLE_BITS'(DIR_Z[i]));
    end
    wait_results();

    // A write beyond the register map must leave num_sensors alone.
    apb_write(ADDR_UNMAPPED, APB_DW'(5));
    apb_read_sensors();

    run_phase(1024, 0, 0, 200, 1'b1, 0);
    run_phase(2, 77, 0, 150, 1'b0, 0);
    run_phase(2047, 0, 77, 200, 1'b0, 0);
    run_phase(0, 23, 23, 100, 1'b0, 0);
    run_phase(1, 0, 0, 60, 1'b0, 0);
    run_phase($urandom_range(1024, 2), 23, 23, 200, 1'b0, 40);
    run_phase(1025, 77, 0, 140, 1'b0, 0);
    run_phase($urandom_range(1024, 2), 0, 77, 200, 1'b0, 0);
    run_phase($urandom_range(1024, 2), 0, 0, 250, 1'b1, 25);

    repeat (PIPE_LATENCY + 8) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("accel_roll_sector_top regression: pass");
    end else begin
      $display("accel_roll_sector_top regression: fail");
    end
    $finish;
  end

endmodule
